FILE: hw/rtl/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

    // Buffer geometry.
    localparam int DEPTH         = 16;
    localparam int MAX_CONSUMERS = 8;
    localparam int DATA_W        = 16;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int CONS_W        = $clog2(MAX_CONSUMERS);
    localparam int CNT_W         = $clog2(MAX_CONSUMERS + 1);

    // Fixed port widths.
    localparam int ID_W     = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

FILE: hw/rtl/brb_ctrl.sv
`timescale 1ns / 1ps

module brb_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output brb_pkg::cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic exec;

    // A new word is taken only in idle; execution waits for a free output slot.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign exec     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Next state and output valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd.load  = accept;
    assign cmd.exec  = exec;

endmodule

FILE: hw/rtl/brb_datapath.sv
`timescale 1ns / 1ps

module brb_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  brb_pkg::cmd_t                       cmd,
    input  logic                                cfg_write_en,
    input  logic [brb_pkg::CFG_W-1:0]           cfg_write_data,
    input  logic                                opcode,
    input  logic [brb_pkg::ID_W-1:0]            consumer_id,
    input  logic [brb_pkg::DATA_W-1:0]          write_data,
    output logic [brb_pkg::STATUS_W-1:0]        status,
    output logic [brb_pkg::DATA_W-1:0]          read_data,
    output logic [brb_pkg::SLOT_W-1:0]          slot_index
);

    localparam logic [brb_pkg::PTR_W-1:0] LAST_SLOT =
        brb_pkg::PTR_W'(brb_pkg::DEPTH - 1);
    localparam logic [brb_pkg::CNT_W-1:0] MAX_CNT =
        brb_pkg::CNT_W'(brb_pkg::MAX_CONSUMERS);

    // Configuration and latched request.
    logic [brb_pkg::CFG_W-1:0]  consumer_count_reg;
    logic                       op_reg;
    logic [brb_pkg::ID_W-1:0]   id_reg;
    logic [brb_pkg::DATA_W-1:0] wd_reg;

    // Queue state.
    logic [brb_pkg::DATA_W-1:0] slot_mem [brb_pkg::DEPTH];
    logic [brb_pkg::CNT_W-1:0]  readers_due_reg [brb_pkg::DEPTH];
    logic [brb_pkg::PTR_W-1:0]  wp_reg;
    logic [brb_pkg::PTR_W-1:0]  rp_reg [brb_pkg::MAX_CONSUMERS];

    // Result registers.
    logic [brb_pkg::STATUS_W-1:0] status_reg;
    logic [brb_pkg::PTR_W-1:0]    slot_reg;
    logic                         pop_ok_reg;
    logic [brb_pkg::DATA_W-1:0]   rd_data_reg;

    logic [brb_pkg::CNT_W-1:0]    eff_count;
    logic                         id_active;
    logic [brb_pkg::CONS_W-1:0]   id_idx;
    logic [brb_pkg::PTR_W-1:0]    slot_cur;
    logic [brb_pkg::PTR_W-1:0]    slot_adv;
    logic [brb_pkg::CNT_W-1:0]    due_cur;
    logic                         push_ok;
    logic                         pop_ok;
    logic [brb_pkg::STATUS_W-1:0] status_next;

    // Config register, written only in idle by user; not checked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumer_count_reg <= brb_pkg::CFG_W'(1);
        end
        else if (cfg_write_en)
        begin
            consumer_count_reg <= cfg_write_data;
        end
    end

    // Capture the incoming word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            id_reg <= consumer_id;
            wd_reg <= write_data;
        end
    end

    // Clamp the consumer count into its legal range.
    always_comb
    begin
        if (consumer_count_reg == '0)
        begin
            eff_count = brb_pkg::CNT_W'(1);
        end
        else if (brb_pkg::CNT_W'(consumer_count_reg) > MAX_CNT)
        begin
            eff_count = MAX_CNT;
        end
        else
        begin
            eff_count = brb_pkg::CNT_W'(consumer_count_reg);
        end
    end

    // Slot selection, count check and status.
    assign id_active = ({1'b0, id_reg} < (brb_pkg::ID_W + 1)'(eff_count));
    assign id_idx    = id_reg[brb_pkg::CONS_W-1:0];

    always_comb
    begin
        if (op_reg == brb_pkg::OP_PUSH)
        begin
            slot_cur = wp_reg;
        end
        else if (id_active)
        begin
            slot_cur = rp_reg[id_idx];
        end
        else
        begin
            slot_cur = '0;
        end
    end

    assign slot_adv = (slot_cur == LAST_SLOT) ? '0 : slot_cur + 1'b1;
    assign due_cur  = readers_due_reg[slot_cur];
    assign push_ok  = (op_reg == brb_pkg::OP_PUSH) && (due_cur == '0);
    assign pop_ok   = (op_reg == brb_pkg::OP_POP) && id_active && (due_cur != '0);

    always_comb
    begin
        if (op_reg == brb_pkg::OP_PUSH)
        begin
            status_next = push_ok ? brb_pkg::ST_OK : brb_pkg::ST_FULL;
        end
        else
        begin
            status_next = pop_ok ? brb_pkg::ST_OK : brb_pkg::ST_EMPTY;
        end
    end

    // Counts and pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            for (int i = 0; i < brb_pkg::DEPTH; i++)
            begin
                readers_due_reg[i] <= '0;
            end
            for (int i = 0; i < brb_pkg::MAX_CONSUMERS; i++)
            begin
                rp_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (push_ok)
            begin
                readers_due_reg[slot_cur] <= eff_count;
                wp_reg                    <= slot_adv;
            end
            else if (pop_ok)
            begin
                readers_due_reg[slot_cur] <= due_cur - 1'b1;
                rp_reg[id_idx]            <= slot_adv;
            end
        end
    end

    // Word store with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (push_ok)
            begin
                slot_mem[slot_cur] <= wd_reg;
            end
            rd_data_reg <= slot_mem[slot_cur];
        end
    end

    // Result word held until it is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_cur;
            pop_ok_reg <= pop_ok;
        end
    end

    assign status     = status_reg;
    assign slot_index = brb_pkg::SLOT_W'(slot_reg);
    assign read_data  = pop_ok_reg ? rd_data_reg : '0;

    // An accepted push arms its slot with the full reader count.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && push_ok |=> readers_due_reg[$past(slot_cur)] == $past(eff_count))
        else $error("push did not load the reader count");

    // An accepted pop takes exactly one reader off its slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && pop_ok |=> readers_due_reg[$past(slot_cur)] == $past(due_cur) - 1'b1)
        else $error("pop did not decrement the reader count");

    // A refused operation leaves the write pointer alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !push_ok && !pop_ok |=> $stable(wp_reg))
        else $error("refused operation moved the write pointer");

endmodule

FILE: hw/rtl/broadcast_ring_buffer_top.sv
`timescale 1ns / 1ps
// A word accepted in idle is captured into the request registers; the access step then loads
// the result registers and raises out_valid, waiting while the previous result is still held.
// The capture step and the single slot/count access step run one after the other, and no new
// word is taken until the access step is done; the access step waits while a result is held.
// A new word may be accepted while the previous result still waits on the output.
// Reset clears all reader counts and pointers and sets consumer_count to 1; words are kept.

module broadcast_ring_buffer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [brb_pkg::CFG_W-1:0]           cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [brb_pkg::ID_W-1:0]            consumer_id,
    input  logic [brb_pkg::DATA_W-1:0]          write_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [brb_pkg::STATUS_W-1:0]        status,
    output logic [brb_pkg::DATA_W-1:0]          read_data,
    output logic [brb_pkg::SLOT_W-1:0]          slot_index
);

    brb_pkg::cmd_t cmd;

    // Sequencing of capture, execution and output handshake.
    brb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Slot store, reader counts and pointers.
    brb_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .consumer_id    (consumer_id),
        .write_data     (write_data),
        .status         (status),
        .read_data      (read_data),
        .slot_index     (slot_index)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    // One result word as the block reports it.
    typedef struct packed {
        logic [brb_pkg::STATUS_W-1:0] status;
        logic [brb_pkg::DATA_W-1:0]   data;
        logic [brb_pkg::SLOT_W-1:0]   slot;
    } access_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write_en;
    logic [brb_pkg::CFG_W-1:0]    cfg_write_data;
    logic                         in_valid;
    logic                         in_stall;
    logic                         opcode;
    logic [brb_pkg::ID_W-1:0]     consumer_id;
    logic [brb_pkg::DATA_W-1:0]   write_data;
    logic                         out_valid;
    logic                         out_stall;
    logic [brb_pkg::STATUS_W-1:0] status;
    logic [brb_pkg::DATA_W-1:0]   read_data;
    logic [brb_pkg::SLOT_W-1:0]   slot_index;

    // Shadow copy of the ring: stored words, readers still due per slot, pointers.
    logic [brb_pkg::DATA_W-1:0]   ring_words [brb_pkg::DEPTH];
    logic [3:0]                   ring_due [brb_pkg::DEPTH];
    logic [brb_pkg::SLOT_W-1:0]   ring_wr_ptr;
    logic [brb_pkg::SLOT_W-1:0]   ring_rd_ptr [brb_pkg::MAX_CONSUMERS];
    logic [brb_pkg::CFG_W-1:0]    ring_consumers;

    access_result_t      awaited_results[$];
    int unsigned         burst_left;
    int unsigned         err_count;
    int unsigned         cycle_count;

    broadcast_ring_buffer_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .consumer_id    (consumer_id),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .slot_index     (slot_index)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[broadcast_ring_buffer_top] ERROR");
            $finish;
        end
    end

    // Number of consumers that actually take part, after clamping the register.
    function automatic int unsigned active_readers();
        int unsigned n;
        n = ring_consumers;
        if (n == 0)
            n = 1;
        if (n > brb_pkg::MAX_CONSUMERS)
            n = brb_pkg::MAX_CONSUMERS;
        return n;
    endfunction

    function automatic logic [brb_pkg::SLOT_W-1:0] next_slot(
        input logic [brb_pkg::SLOT_W-1:0] slot);
        return (slot == brb_pkg::DEPTH - 1) ? '0 : slot + 1'b1;
    endfunction

    // Apply one push or pop to the shadow ring and return the word the block should report.
    function automatic access_result_t predict_access(input logic op,
                                                      input logic [brb_pkg::ID_W-1:0] id,
                                                      input logic [brb_pkg::DATA_W-1:0] wd);
        access_result_t             res;
        logic [brb_pkg::SLOT_W-1:0] slot;
        res.status = brb_pkg::ST_OK;
        res.data   = '0;
        res.slot   = '0;
        if (op == brb_pkg::OP_PUSH)
        begin
            slot     = ring_wr_ptr;
            res.slot = slot;
            if (ring_due[slot] != 0)
                res.status = brb_pkg::ST_FULL;
            else
            begin
                ring_words[slot] = wd;
                ring_due[slot]   = 4'(active_readers());
                ring_wr_ptr      = next_slot(slot);
            end
        end
        else if (id >= active_readers())
            // A consumer beyond the active count is always refused at slot zero.
            res.status = brb_pkg::ST_EMPTY;
        else
        begin
            slot     = ring_rd_ptr[id];
            res.slot = slot;
            if (ring_due[slot] == 0)
                res.status = brb_pkg::ST_EMPTY;
            else
            begin
                res.data        = ring_words[slot];
                ring_due[slot]  = ring_due[slot] - 1'b1;
                ring_rd_ptr[id] = next_slot(slot);
            end
        end
        return res;
    endfunction

    // Pick an active consumer that has a word waiting, or -1 if none does.
    function automatic int ready_reader();
        int picks[$];
        for (int i = 0; i < active_readers(); i++)
        begin
            if (ring_due[ring_rd_ptr[i]] != 0)
                picks.push_back(i);
        end
        if (picks.size() == 0)
            return -1;
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // Offer one word in bursts with random gaps; called and returns at a rising edge.
    task automatic send_word(input logic op, input logic [brb_pkg::ID_W-1:0] id,
                             input logic [brb_pkg::DATA_W-1:0] wd);
        int unsigned gap;
        bit          taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid    <= 1'b1;
        opcode      <= op;
        consumer_id <= id;
        write_data  <= wd;
        taken = 1'b0;
        while (!taken)
        begin
            // Stall is sampled mid-cycle, where nothing is changing.
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        awaited_results.push_back(predict_access(op, id, wd));
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic wait_for_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_consumer_count(input logic [brb_pkg::CFG_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        ring_consumers  = value;
        @(posedge clk);
    endtask

    // Pops on an empty ring and by a consumer outside the active set, then a push and its pops.
    task automatic test_empty_and_inactive();
        write_consumer_count(4'd1);
        send_word(brb_pkg::OP_POP, 3'd0, 16'h1234);
        send_word(brb_pkg::OP_POP, 3'd7, 16'hFFFF);
        send_word(brb_pkg::OP_PUSH, 3'd5, 16'h0000);
        send_word(brb_pkg::OP_POP, 3'd0, 16'h0000);
        send_word(brb_pkg::OP_POP, 3'd0, 16'h0000);
    endtask

    // Fill every slot, the first six with edge-case words, hit full, then read one back.
    task automatic test_fill_to_full();
        logic [brb_pkg::DATA_W-1:0] wd;
        for (int i = 0; i < brb_pkg::DEPTH; i++)
        begin
            case (i)
                0:       wd = 16'hFFFF;
                1:       wd = 16'h0000;
                2:       wd = 16'h8000;
                3:       wd = 16'h0001;
                4:       wd = 16'h5555;
                5:       wd = 16'hAAAA;
                default: wd = 16'($urandom);
            endcase
            send_word(brb_pkg::OP_PUSH, 3'($urandom_range(0, 7)), wd);
        end
        send_word(brb_pkg::OP_PUSH, 3'd7, 16'hFFFF);
        send_word(brb_pkg::OP_POP, 3'd0, 16'hFFFF);
    endtask

    // Register values outside the legal range clamp to one and to the maximum.
    task automatic test_count_limits();
        wait_for_idle();
        write_consumer_count(4'd0);
        send_word(brb_pkg::OP_POP, 3'd1, 16'h0000);
        send_word(brb_pkg::OP_POP, 3'd0, 16'h0000);
        wait_for_idle();
        write_consumer_count(4'd15);
        send_word(brb_pkg::OP_POP, 3'd7, 16'h0000);
        send_word(brb_pkg::OP_PUSH, 3'd0, 16'hFFFF);
    endtask

    // Mostly well-formed traffic under one consumer count, then a full drain.
    task automatic test_random_traffic(input logic [brb_pkg::CFG_W-1:0] readers,
                                       input int unsigned items);
        int unsigned                push_weight;
        int                         pick;
        logic [brb_pkg::DATA_W-1:0] wd;
        logic [brb_pkg::ID_W-1:0]   id;
        wait_for_idle();
        write_consumer_count(readers);
        push_weight = 50;
        for (int unsigned i = 0; i < items; i++)
        begin
            // Shift between filling, balanced and draining stretches.
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_weight = 15;
                    1:       push_weight = 50;
                    default: push_weight = 85;
                endcase
            end
            wd = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
                wd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            id = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < push_weight)
                send_word(brb_pkg::OP_PUSH, id, wd);
            else
            begin
                pick = ready_reader();
                if (pick >= 0 && $urandom_range(0, 9) < 8)
                    id = 3'(pick);
                send_word(brb_pkg::OP_POP, id, wd);
            end
        end
        for (int j = 0; j < active_readers(); j++)
        begin
            while (ring_due[ring_rd_ptr[j]] != 0)
                send_word(brb_pkg::OP_POP, 3'(j), 16'($urandom));
        end
    endtask

    // Output stall follows its own pattern, switching to a new random mode after each random span.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (int unsigned k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (k % 3 == 0);
                endcase
            end
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(negedge clk)
    begin
        access_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result word with nothing outstanding: status %0d data %h slot %0d",
                       status, read_data, slot_index);
                err_count++;
            end
            else
            begin
                exp_res = awaited_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    err_count++;
                end
                if (read_data !== exp_res.data)
                begin
                    $error("read_data: expected %h, got %h", exp_res.data, read_data);
                    err_count++;
                end
                if (slot_index !== exp_res.slot)
                begin
                    $error("slot_index: expected %0d, got %0d", exp_res.slot, slot_index);
                    err_count++;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        cycle_count     = 0;
        err_count       = 0;
        burst_left      = 0;
        ring_wr_ptr     = '0;
        ring_consumers  = 4'd1;
        for (int i = 0; i < brb_pkg::DEPTH; i++)
            ring_due[i] = '0;
        for (int i = 0; i < brb_pkg::MAX_CONSUMERS; i++)
            ring_rd_ptr[i] = '0;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        opcode         <= brb_pkg::OP_PUSH;
        consumer_id    <= '0;
        write_data     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_inactive();
        test_fill_to_full();
        test_count_limits();
        test_random_traffic(4'd8, 175);
        test_random_traffic(4'd3, 175);
        test_random_traffic(4'd1, 175);
        test_random_traffic(4'd15, 175);
        test_random_traffic(4'd5, 175);
        test_random_traffic(4'd0, 175);
        test_random_traffic(4'd2, 175);
        test_random_traffic(4'd8, 175);
        test_random_traffic(4'd7, 175);
        test_random_traffic(4'd4, 150);

        wait_for_idle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("[broadcast_ring_buffer_top] OK");
        else
            $display("[broadcast_ring_buffer_top] ERROR");
        $finish;
    end

endmodule
